>>> hdl/crcfp_pkg.sv
`timescale 1ns / 1ps
// crcfp_pkg: types, codes and the crc-8 step shared by the command parser
// no dependencies; imported by every module of the parser

package crcfp_pkg;

	localparam int AddrW = 7;
	localparam int DataW = 16;

	// configuration register indexes
	localparam logic [1:0] REG_SERVO_ADDR = 2'd0;
	localparam logic [1:0] REG_MOTOR_ADDR = 2'd1;
	localparam logic [1:0] REG_IMU_ADDR   = 2'd2;

	// write event codes
	localparam logic [1:0] EV_SERVO = 2'd0;
	localparam logic [1:0] EV_MOTOR = 2'd1;
	localparam logic [1:0] EV_IMU   = 2'd2;
	localparam logic [1:0] EV_OTHER = 2'd3;

	// result kinds
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam logic [7:0] CrcPoly = 8'h07;

	typedef struct packed {
		logic             is_read;
		logic [AddrW-1:0] addr;
		logic [DataW-1:0] data;
	} cmd_t;

	typedef struct packed {
		logic [AddrW-1:0] servo_addr;
		logic [AddrW-1:0] motor_addr;
		logic [AddrW-1:0] imu_addr;
	} cfg_t;

	// one byte of crc-8, msb first, no reflection
	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CrcPoly;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

>>> hdl/crcfp_if.sv
`timescale 1ns / 1ps
// crcfp byte and result channels: valid/ready with payload
// depends on nothing; used by the parser top level and its back end

interface crcfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface crcfp_result_if;
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [1:0]         event_code;
	logic [6:0]         reg_addr;
	logic signed [15:0] reg_value;
	logic               last_of_run;

	modport source (output valid, output result_kind, output event_code, output reg_addr,
		output reg_value, output last_of_run, input ready);
	modport sink (input valid, input result_kind, input event_code, input reg_addr,
		input reg_value, input last_of_run, output ready);
endinterface

>>> hdl/crcfp_front.sv
`timescale 1ns / 1ps
// crcfp_front: frame assembly and crc check, one byte per transfer
// depends on crcfp_pkg

module crcfp_front
	import crcfp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       byte_valid,
	input  logic [7:0] byte_data,
	output logic       byte_ready,
	input  logic       cmd_ready,
	output logic       cmd_push,
	output cmd_t       cmd
);

	logic [1:0] phase_q;
	logic [7:0] crc_q;
	logic [7:0] hdr_q;
	logic [7:0] lo_q;
	logic [7:0] hi_q;
	logic       take;

	assign byte_ready = cmd_ready;
	assign take       = byte_valid && byte_ready;

	assign cmd_push    = take && (phase_q == 2'd3) && (crc_q == byte_data);
	assign cmd.is_read = hdr_q[7];
	assign cmd.addr    = hdr_q[6:0];
	assign cmd.data    = {hi_q, lo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			crc_q   <= 8'd0;
			hdr_q   <= 8'd0;
			lo_q    <= 8'd0;
			hi_q    <= 8'd0;
		end else if (take) begin
			phase_q <= phase_q + 2'd1;
			unique case (phase_q)
				2'd0: begin
					hdr_q <= byte_data;
					crc_q <= crc8_step(8'd0, byte_data);
				end
				2'd1: begin
					lo_q  <= byte_data;
					crc_q <= crc8_step(crc_q, byte_data);
				end
				2'd2: begin
					hi_q  <= byte_data;
					crc_q <= crc8_step(crc_q, byte_data);
				end
				default: begin
					crc_q <= 8'd0;
				end
			endcase
		end
	end

endmodule

>>> hdl/crcfp_fifo.sv
`timescale 1ns / 1ps
// crcfp_fifo: short command queue between frame check and execution
// depends on crcfp_pkg

module crcfp_fifo
	import crcfp_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic not_full,
	input  logic pop,
	output logic not_empty,
	output cmd_t head
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	cmd_t            mem_q [DEPTH];
	logic [PtrW-1:0] wr_q;
	logic [PtrW-1:0] rd_q;
	logic [CntW-1:0] fill_q;

	assign not_full  = (fill_q != CntW'(DEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/crcfp_back.sv
`timescale 1ns / 1ps
// crcfp_back: command execution, shadow registers and the result register
// depends on crcfp_pkg and crcfp_if

module crcfp_back
	import crcfp_pkg::*;
#(
	parameter int MAX_BURST = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	crcfp_result_if.source res
);

	localparam int CntW = $clog2(MAX_BURST + 1);

	logic             busy_q;
	logic             is_read_q;
	logic [AddrW-1:0] addr_q;
	logic [DataW-1:0] data_q;
	logic [CntW-1:0]  cnt_q;
	logic [7:0]       servo_q;
	logic [DataW-1:0] motor_q;

	logic             out_valid_q;
	logic             out_kind_q;
	logic [1:0]       out_code_q;
	logic [AddrW-1:0] out_addr_q;
	logic [DataW-1:0] out_value_q;
	logic             out_last_q;

	logic             adv;
	logic [CntW-1:0]  burst_len;
	logic [DataW-1:0] rd_value;
	logic [1:0]       wr_code;

	assign adv     = !out_valid_q || res.ready;
	assign cmd_pop = !busy_q && cmd_valid;

	// read count from the low data byte, saturated
	always_comb begin
		if (cmd.data[7:0] > 8'(MAX_BURST)) begin
			burst_len = CntW'(MAX_BURST);
		end else begin
			burst_len = CntW'(cmd.data[7:0]);
		end
	end

	// servo wins over motor on equal addresses
	always_comb begin
		priority if (addr_q == cfg.servo_addr) begin
			rd_value = {{8{servo_q[7]}}, servo_q};
		end else if (addr_q == cfg.motor_addr) begin
			rd_value = motor_q;
		end else begin
			rd_value = '0;
		end
	end

	always_comb begin
		priority if (addr_q == cfg.servo_addr) begin
			wr_code = EV_SERVO;
		end else if (addr_q == cfg.motor_addr) begin
			wr_code = EV_MOTOR;
		end else if (addr_q == cfg.imu_addr) begin
			wr_code = EV_IMU;
		end else begin
			wr_code = EV_OTHER;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			servo_q     <= '0;
			motor_q     <= '0;
		end else begin
			if (cmd_pop) begin
				busy_q <= !(cmd.is_read && (burst_len == '0));
			end else if (busy_q && adv) begin
				if (!is_read_q || (cnt_q == CntW'(1))) begin
					busy_q <= 1'b0;
				end
			end
			if (adv) begin
				out_valid_q <= busy_q;
			end
			if (busy_q && adv && !is_read_q) begin
				if (wr_code == EV_SERVO) begin
					servo_q <= data_q[7:0];
				end else if (wr_code == EV_MOTOR) begin
					motor_q <= data_q;
				end
			end
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			is_read_q <= cmd.is_read;
			addr_q    <= cmd.addr;
			data_q    <= cmd.data;
			cnt_q     <= burst_len;
		end else if (busy_q && adv) begin
			addr_q <= addr_q + 1'b1;
			cnt_q  <= cnt_q - 1'b1;
		end
		if (busy_q && adv) begin
			out_addr_q <= addr_q;
			if (is_read_q) begin
				out_kind_q  <= KIND_READ;
				out_code_q  <= EV_SERVO;
				out_value_q <= rd_value;
				out_last_q  <= (cnt_q == CntW'(1));
			end else begin
				out_kind_q  <= KIND_WRITE;
				out_code_q  <= wr_code;
				out_value_q <= data_q;
				out_last_q  <= 1'b1;
			end
		end
	end

	assign res.valid       = out_valid_q;
	assign res.result_kind = out_kind_q;
	assign res.event_code  = out_code_q;
	assign res.reg_addr    = out_addr_q;
	assign res.reg_value   = out_value_q;
	assign res.last_of_run = out_last_q;

endmodule

>>> hdl/crc_framed_register_command_parser.sv
`timescale 1ns / 1ps
// crc_framed_register_command_parser: top level of the crc-8 framed command parser
// depends on crcfp_pkg, crcfp_if, crcfp_front, crcfp_fifo, crcfp_back
//
// usage
//  rx carries received bytes, one per transfer; every fourth byte closes a
//  frame (header, data low, data high, crc-8 over the first three)
//  res carries results: one write event per good write frame, or one read
//  word per register of a read burst, last_of_run marking the final one
//  cfg_we/cfg_index/cfg_wdata set the servo, motor and imu addresses; write
//  them only while the parser is idle
// timing
//  a good frame enters the queue at its crc byte's transfer; once idle, the
//  executer pops it into its command registers, then registers the first
//  result, which res shows; bursts then give one word per cycle while res
//  is ready; the executer takes no new command until the last result of the
//  one before is registered, so the sustained rate is set by that executer loop
// reset and stall
//  reset returns to the header phase, clears both shadows and loads address
//  defaults 0, 1 and 2; a stalled res holds its word and fills the queue,
//  after which rx drops ready until the queue drains

module crc_framed_register_command_parser
	import crcfp_pkg::*;
#(
	parameter int MAX_BURST   = 64,
	parameter int QUEUE_DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [AddrW-1:0] cfg_wdata,
	crcfp_byte_if.sink       rx,
	crcfp_result_if.source   res
);

	cfg_t cfg_q;
	cmd_t front_cmd;
	cmd_t head_cmd;
	logic push;
	logic q_not_full;
	logic q_not_empty;
	logic pop;

	// address registers; index beyond the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.servo_addr <= AddrW'(0);
			cfg_q.motor_addr <= AddrW'(1);
			cfg_q.imu_addr   <= AddrW'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SERVO_ADDR: cfg_q.servo_addr <= cfg_wdata;
				REG_MOTOR_ADDR: cfg_q.motor_addr <= cfg_wdata;
				REG_IMU_ADDR:   cfg_q.imu_addr   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// front: frame assembly and crc check
	crcfp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (rx.valid),
		.byte_data  (rx.rx_byte),
		.byte_ready (rx.ready),
		.cmd_ready  (q_not_full),
		.cmd_push   (push),
		.cmd        (front_cmd)
	);

	// queue of checked commands
	crcfp_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (front_cmd),
		.not_full  (q_not_full),
		.pop       (pop),
		.not_empty (q_not_empty),
		.head      (head_cmd)
	);

	// back: execution and result register
	crcfp_back #(
		.MAX_BURST (MAX_BURST)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (q_not_empty),
		.cmd       (head_cmd),
		.cmd_pop   (pop),
		.res       (res)
	);

endmodule
